### rtl/adcdc_pkg.sv
`default_nettype none

package adcdc_pkg;

  localparam int COEF_W    = 16;
  localparam int GAIN_W    = 13;
  localparam int CODE_W    = 12;
  localparam int DX_W      = CODE_W + 1;
  localparam int Y_W       = 32;
  localparam int PCM_W     = 16;
  localparam int MUL_A_W   = Y_W + 1;
  localparam int MUL_B_W   = COEF_W + 2;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int YSH_W     = PROD_W - COEF_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd65349;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 13'd256;

  // 999/1000 of 2^30, floored: clamp when |p| exceeds this
  localparam logic signed [PROD_W-1:0] CLIP_LIMIT = 51'sd1072668082;
  localparam logic signed [PCM_W-1:0]  PCM_LIMIT  = 16'sd32734;
  localparam logic signed [PROD_W-1:0] FILT_RND   = 51'sd32768;
  localparam logic signed [PROD_W-1:0] PCM_RND    = 51'sd536870912;

  // register index = paddr[2]
  localparam logic REG_COEF = 1'b0;
  localparam logic REG_GAIN = 1'b1;

endpackage

`default_nettype wire

### rtl/adc_dc_block_gain_clamp_unit.sv
// ADC DC-block, gain and clamp unit.
// in_*  : one beat per converter response; tdata[7:0] = second response byte
//         (low nibble = code bits 11..8), tdata[15:8] = third byte (bits 7..0).
// out_* : one beat per input beat; tdata = signed 16-bit PCM, tuser = clipped.
// cfg_* : APB write/read of filter_coefficient (0x0) and gain_q4_8 (0x4).
// Each sample runs through a sequencer around one shared 33x18 signed
// multiplier, used three times: (1-a)*dx, a*y1 and y*gain. The filter sum
// is formed in the SUM state after the second product; the clamp compare
// and the PCM rounding share the OUT state after the third.
// States run IDLE, MUL_DX, MUL_Y1, SUM, MUL_G, OUT; out_tvalid rises as
// OUT loads the output register. in_tready is high only while idle, so
// a new sample waits until the last has left OUT. If out_tready is low,
// the finished result waits in the output register and the next sample
// may already be taken; its result is held back until the output drains.
// Reset clears the filter history to zero, loads the default coefficient
// (65349) and gain (1.0), and empties the output register.
`default_nettype none

module adc_dc_block_gain_clamp_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [15:0]                          in_tdata,   // resp_mid_byte, resp_low_byte
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [15:0]                          out_tdata,  // pcm_sample
  output logic [0:0]                           out_tuser,  // clipped
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire  [adcdc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [adcdc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [adcdc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);
  import adcdc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_DX = 3'd1;
  localparam logic [2:0] ST_MUL_Y1 = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_MUL_G  = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [COEF_W-1:0]         coef_r;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [CODE_W-1:0]  prev_input_r;
  logic signed [Y_W-1:0]     prev_output_r;
  logic signed [CODE_W-1:0]  x_r;
  logic signed [DX_W-1:0]    dx_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [Y_W-1:0]     y_r;
  logic                      out_valid_r;
  logic [PCM_W-1:0]          out_pcm_r;
  logic                      out_clip_r;

  logic                      in_acc;
  logic                      cfg_wr;
  logic [CODE_W-1:0]         code;
  logic signed [CODE_W-1:0]  x_new;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [COEF_W:0]           one_minus_a;
  logic signed [PROD_W-1:0]  sum;
  logic signed [YSH_W-1:0]   ysh;
  logic signed [Y_W-1:0]     y_sat;
  logic                      clip_hi, clip_lo, p_neg;
  logic [PROD_W-1:0]         q_rnd;
  logic [PCM_W-1:0]          pcm_val;
  logic                      out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pcm_r;
  assign out_tuser  = out_clip_r;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_COEF: cfg_prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_r};
      REG_GAIN: cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, gain_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // code - 2048 in 12-bit two's complement is the code with its MSB flipped
  assign code  = {in_tdata[3:0], in_tdata[15:8]};
  assign x_new = $signed({~code[CODE_W-1], code[CODE_W-2:0]});

  assign one_minus_a = {1'b1, {COEF_W{1'b0}}} - {1'b0, coef_r};

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_MUL_DX: begin
        mul_a = {{(MUL_A_W-DX_W){dx_r[DX_W-1]}}, dx_r};
        mul_b = {1'b0, one_minus_a};
      end
      ST_MUL_Y1: begin
        mul_a = {prev_output_r[Y_W-1], prev_output_r};
        mul_b = {2'b00, coef_r};
      end
      ST_MUL_G: begin
        mul_a = {y_r[Y_W-1], y_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // filter sum, floor shift and saturation
  assign sum = acc_r + prod_r;
  assign ysh = sum[PROD_W-1:COEF_W];
  always_comb begin
    if (ysh[YSH_W-1:Y_W-1] == '0 || ysh[YSH_W-1:Y_W-1] == '1) begin
      y_sat = ysh[Y_W-1:0];
    end else if (ysh[YSH_W-1]) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  // clamp and PCM rounding (ties away from zero)
  assign clip_hi = prod_r > CLIP_LIMIT;
  assign clip_lo = prod_r < -CLIP_LIMIT;
  assign p_neg   = prod_r[PROD_W-1];
  assign q_rnd   = (prod_r <<< 15) - prod_r + PCM_RND - {{(PROD_W-1){1'b0}}, p_neg};
  always_comb begin
    priority if (clip_hi) begin
      pcm_val = PCM_LIMIT;
    end else if (clip_lo) begin
      pcm_val = -PCM_LIMIT;
    end else begin
      pcm_val = q_rnd[30+PCM_W-1:30];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_MUL_DX;
      ST_MUL_DX: state_nxt = ST_MUL_Y1;
      ST_MUL_Y1: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_MUL_G;
      ST_MUL_G:  state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      coef_r        <= COEF_RESET;
      gain_r        <= GAIN_RESET;
      prev_input_r  <= '0;
      prev_output_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_COEF: coef_r <= cfg_pwdata[COEF_W-1:0];
          REG_GAIN: gain_r <= cfg_pwdata[GAIN_W-1:0];
          default:  ;
        endcase
      end
      if (state_r == ST_SUM) begin
        prev_input_r  <= x_r;
        prev_output_r <= y_sat;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r  <= x_new;
      dx_r <= $signed({x_new[CODE_W-1], x_new})
            - $signed({prev_input_r[CODE_W-1], prev_input_r});
    end
    if (state_r == ST_MUL_DX || state_r == ST_MUL_Y1 || state_r == ST_MUL_G) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_MUL_Y1) begin
      acc_r <= (prod_r <<< 11) + FILT_RND;
    end
    if (state_r == ST_SUM) begin
      y_r <= y_sat;
    end
    if (state_r == ST_OUT && out_free) begin
      out_pcm_r  <= pcm_val;
      out_clip_r <= clip_hi || clip_lo;
    end
  end

endmodule

`default_nettype wire
